### rtl/i2cras_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cras_pkg;

    // func codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // engine commands
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_RESTART = 3'd2;
    localparam logic [2:0] CMD_STOP    = 3'd3;
    localparam logic [2:0] CMD_SEND    = 3'd4;
    localparam logic [2:0] CMD_RECV    = 3'd5;
    localparam logic [2:0] CMD_ACK     = 3'd6;

    // transfer status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_COLL    = 2'd2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    typedef enum logic [4:0] {
        PH_IDLE, PH_START_IDLE, PH_START_PEND, PH_DEV_TBF, PH_DEV_ACK,
        PH_REG_IDLE, PH_REG_TBF, PH_REG_ACK, PH_DATA_IDLE, PH_DATA_TBF,
        PH_DATA_ACK, PH_RS_IDLE, PH_RS_PEND, PH_RD_TBF, PH_RD_ACK,
        PH_RX_IDLE, PH_RX_PEND, PH_ACK_IDLE, PH_ACK_PEND, PH_FIN_IDLE,
        PH_STOP_PEND, PH_END_IDLE
    } phase_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic [7:0] read_count;
        logic       engine_busy;
        logic       condition_pending;
        logic       transmit_full;
        logic       ack_missing;
        logic       write_collision;
        logic [7:0] received_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0] engine_command;
        logic [7:0] command_byte;
        logic       ack_level;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       read_last;
        logic       transfer_done;
        logic [1:0] transfer_status;
        logic       sequencer_busy;
    } out_item_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] wait_counter;
        logic [7:0]  byte_index;
        logic        is_read;
        logic [7:0]  saved_device;
        logic [7:0]  saved_register;
        logic [7:0]  saved_data;
        logic [7:0]  saved_count;
    } seq_state_t;

endpackage

`default_nettype wire

### rtl/i2cras_step.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cras_step (
    input  wire i2cras_pkg::seq_state_t st_reg,
    input  wire i2cras_pkg::in_item_t   item,
    input  wire logic [15:0]            timeout_limit,
    output i2cras_pkg::seq_state_t      st_next,
    output i2cras_pkg::out_item_t       res_next
);
    import i2cras_pkg::*;

    logic       wait_flag;
    logic       wait_timeout;
    logic       coll_abort;
    logic       tbf_phase;
    logic [8:0] index_plus1;
    logic       is_last;
    logic [7:0] index_inc;

    // flag that the current phase waits on
    always_comb begin
        wait_flag = 1'b0;
        tbf_phase = 1'b0;
        unique case (st_reg.phase)
            PH_START_IDLE, PH_REG_IDLE, PH_DATA_IDLE, PH_RS_IDLE,
            PH_RX_IDLE, PH_ACK_IDLE, PH_FIN_IDLE, PH_END_IDLE: begin
                wait_flag = item.engine_busy;
            end
            PH_START_PEND, PH_RS_PEND, PH_RX_PEND, PH_ACK_PEND, PH_STOP_PEND: begin
                wait_flag = item.condition_pending;
            end
            PH_DEV_TBF, PH_REG_TBF, PH_DATA_TBF, PH_RD_TBF: begin
                wait_flag = item.transmit_full;
                tbf_phase = 1'b1;
            end
            PH_DEV_ACK, PH_REG_ACK, PH_DATA_ACK, PH_RD_ACK: begin
                wait_flag = item.ack_missing;
            end
            default: begin
                wait_flag = 1'b0;
            end
        endcase
    end

    // collision is checked only on the first tick after a send
    assign coll_abort   = tbf_phase && (st_reg.wait_counter == 16'd0) && item.write_collision;
    assign wait_timeout = wait_flag && (st_reg.wait_counter >= timeout_limit);
    assign index_plus1  = {1'b0, st_reg.byte_index} + 9'd1;
    assign is_last      = (index_plus1 == {1'b0, st_reg.saved_count});
    assign index_inc    = index_plus1[7:0];

    // next state
    always_comb begin
        st_next = st_reg;
        if (st_reg.phase == PH_IDLE) begin
            if (item.func == FUNC_WRITE || item.func == FUNC_READ) begin
                st_next.is_read        = (item.func == FUNC_READ);
                st_next.saved_device   = item.device_address;
                st_next.saved_register = item.register_address;
                st_next.saved_data     = item.write_data;
                st_next.saved_count    = item.read_count;
                st_next.byte_index     = 8'd0;
                st_next.phase          = PH_START_IDLE;
                st_next.wait_counter   = 16'd0;
            end
        end else if (coll_abort || wait_timeout) begin
            st_next.phase        = PH_IDLE;
            st_next.wait_counter = 16'd0;
        end else if (wait_flag) begin
            st_next.wait_counter = st_reg.wait_counter + 16'd1;
        end else begin
            st_next.wait_counter = 16'd0;
            unique case (st_reg.phase)
                PH_START_IDLE: st_next.phase = PH_START_PEND;
                PH_REG_IDLE:   st_next.phase = PH_REG_TBF;
                PH_DATA_IDLE:  st_next.phase = PH_DATA_TBF;
                PH_RS_IDLE:    st_next.phase = PH_RS_PEND;
                PH_RX_IDLE:    st_next.phase = PH_RX_PEND;
                PH_ACK_IDLE:   st_next.phase = PH_ACK_PEND;
                PH_FIN_IDLE:   st_next.phase = PH_STOP_PEND;
                PH_END_IDLE:   st_next.phase = PH_IDLE;
                PH_START_PEND: st_next.phase = PH_DEV_TBF;
                PH_RS_PEND:    st_next.phase = PH_RD_TBF;
                PH_RX_PEND:    st_next.phase = PH_ACK_IDLE;
                PH_ACK_PEND: begin
                    st_next.byte_index = index_inc;
                    st_next.phase = (index_inc < st_reg.saved_count) ? PH_RX_IDLE
                                                                      : PH_FIN_IDLE;
                end
                PH_STOP_PEND:  st_next.phase = PH_END_IDLE;
                PH_DEV_TBF:    st_next.phase = PH_DEV_ACK;
                PH_REG_TBF:    st_next.phase = PH_REG_ACK;
                PH_DATA_TBF:   st_next.phase = PH_DATA_ACK;
                PH_RD_TBF:     st_next.phase = PH_RD_ACK;
                PH_DEV_ACK:    st_next.phase = PH_REG_IDLE;
                PH_REG_ACK:    st_next.phase = st_reg.is_read ? PH_RS_IDLE : PH_DATA_IDLE;
                PH_DATA_ACK:   st_next.phase = PH_FIN_IDLE;
                PH_RD_ACK: begin
                    st_next.phase = (st_reg.saved_count != 8'd0) ? PH_RX_IDLE
                                                                  : PH_FIN_IDLE;
                end
                default:       st_next.phase = PH_IDLE;
            endcase
        end
    end

    // result word
    always_comb begin
        res_next = '0;
        if (coll_abort) begin
            res_next.transfer_done   = 1'b1;
            res_next.transfer_status = ST_COLL;
        end else if (wait_timeout) begin
            res_next.transfer_done   = 1'b1;
            res_next.transfer_status = ST_TIMEOUT;
        end else if (!wait_flag) begin
            unique case (st_reg.phase)
                PH_START_IDLE: res_next.engine_command = CMD_START;
                PH_REG_IDLE: begin
                    res_next.engine_command = CMD_SEND;
                    res_next.command_byte   = st_reg.saved_register;
                end
                PH_DATA_IDLE: begin
                    res_next.engine_command = CMD_SEND;
                    res_next.command_byte   = st_reg.saved_data;
                end
                PH_RS_IDLE:    res_next.engine_command = CMD_RESTART;
                PH_RX_IDLE:    res_next.engine_command = CMD_RECV;
                PH_ACK_IDLE: begin
                    res_next.engine_command = CMD_ACK;
                    res_next.ack_level      = is_last;
                end
                PH_FIN_IDLE:   res_next.engine_command = CMD_STOP;
                PH_END_IDLE: begin
                    res_next.transfer_done   = 1'b1;
                    res_next.transfer_status = ST_OK;
                end
                PH_START_PEND: begin
                    res_next.engine_command = CMD_SEND;
                    res_next.command_byte   = st_reg.saved_device;
                end
                PH_RS_PEND: begin
                    res_next.engine_command = CMD_SEND;
                    res_next.command_byte   = st_reg.saved_device + 8'd1;
                end
                PH_RX_PEND: begin
                    res_next.read_valid = 1'b1;
                    res_next.read_byte  = item.received_byte;
                    res_next.read_last  = is_last;
                end
                default: res_next.engine_command = CMD_NONE;
            endcase
        end
        res_next.sequencer_busy = (st_next.phase != PH_IDLE);
    end

endmodule

`default_nettype wire

### rtl/i2c_register_access_sequencer.sv
// a result word is registered and appears in the cycle after its status word is accepted
// throughput: one word per cycle; the only stall is the result register
// waiting on m_ready, and s_ready drops only while it holds an untaken word
// reset (aresetn, synchronous, active low): sequencer idle, counters cleared,
// timeout limit back to 1000, result register empty
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_access_sequencer (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [15:0]           cfg_wr_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire i2cras_pkg::in_item_t  s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output i2cras_pkg::out_item_t      m_data
);
    import i2cras_pkg::*;

    seq_state_t  st_reg;
    seq_state_t  st_next;
    out_item_t   res_next;
    out_item_t   m_data_reg;
    logic        m_valid_reg;
    logic [15:0] timeout_limit_reg;
    logic        accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    i2cras_step u_step (
        .st_reg        (st_reg),
        .item          (s_data),
        .timeout_limit (timeout_limit_reg),
        .st_next       (st_next),
        .res_next      (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_limit_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            timeout_limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= '{phase: PH_IDLE, default: '0};
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                st_reg      <= st_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

### rtl/i2cras_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cras_checker (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire i2cras_pkg::out_item_t m_data
);
    import i2cras_pkg::*;

    // an untaken result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // a finished transfer leaves the sequencer idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.transfer_done |-> !m_data.sequencer_busy)
        else $error("sequencer busy after transfer end");

    // a failure status only with a finished transfer
    a_status_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.transfer_done |-> m_data.transfer_status == ST_OK)
        else $error("status without transfer end");

    // a received byte comes with no command, mid transfer
    a_read_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.read_valid |->
            m_data.engine_command == CMD_NONE && m_data.sequencer_busy)
        else $error("read word with command or outside transfer");

    // nack level only with the ack command
    a_ack_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.ack_level |-> m_data.engine_command == CMD_ACK)
        else $error("ack level without ack command");

endmodule

bind i2c_register_access_sequencer i2cras_checker u_i2cras_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
